[rtl/core/etc2_pkg.sv]
// Package: shared types, tables and helpers for the ETC2/EAC block decoder.
`default_nettype none
package etc2_pkg;

  typedef enum logic [2:0] {
    MODE_ETC1,
    MODE_T,
    MODE_H,
    MODE_PLANAR
  } mode_t;

  // per-block setup decoded once, shared by every pixel lane
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  r1, g1, b1, r2, g2, b2;
    logic [2:0]  cw1, cw2;
    logic        flip;
    logic [6:0]  tdist;
    logic [7:0]  ro, go, bo, rh, gh, bh, rv, gv, bv;
    logic [31:0] idx;
    logic        alpha_on;
    logic [7:0]  abase;
    logic [3:0]  amult;
    logic [3:0]  atab;
    logic [47:0] aidx;
  } setup_t;

  function automatic logic [6:0] dist_lut(input logic [2:0] k);
    logic [6:0] d;
    unique case (k)
      3'd0: d = 7'd3;
      3'd1: d = 7'd6;
      3'd2: d = 7'd11;
      3'd3: d = 7'd16;
      3'd4: d = 7'd23;
      3'd5: d = 7'd32;
      3'd6: d = 7'd41;
      default: d = 7'd64;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] etc1_lut(input logic [2:0] cw, input logic lsb);
    logic [7:0] a, b;
    unique case (cw)
      3'd0: begin a = 8'd2;  b = 8'd8;   end
      3'd1: begin a = 8'd5;  b = 8'd17;  end
      3'd2: begin a = 8'd9;  b = 8'd29;  end
      3'd3: begin a = 8'd13; b = 8'd42;  end
      3'd4: begin a = 8'd18; b = 8'd60;  end
      3'd5: begin a = 8'd24; b = 8'd80;  end
      3'd6: begin a = 8'd33; b = 8'd106; end
      default: begin a = 8'd47; b = 8'd183; end
    endcase
    return lsb ? b : a;
  endfunction

  // magnitude for index bits 1..0; indices 0..3 negative, 4..7 positive
  function automatic logic [3:0] eac_lut(input logic [3:0] t, input logic [2:0] i);
    logic [15:0] row;
    unique case (t)
      4'd0:  row = {4'd15, 4'd9, 4'd6, 4'd3};
      4'd1:  row = {4'd13, 4'd10, 4'd7, 4'd3};
      4'd2:  row = {4'd13, 4'd8, 4'd5, 4'd2};
      4'd3:  row = {4'd13, 4'd6, 4'd4, 4'd2};
      4'd4:  row = {4'd12, 4'd8, 4'd6, 4'd3};
      4'd5:  row = {4'd11, 4'd9, 4'd7, 4'd3};
      4'd6:  row = {4'd11, 4'd8, 4'd7, 4'd4};
      4'd7:  row = {4'd11, 4'd8, 4'd5, 4'd3};
      4'd8:  row = {4'd10, 4'd8, 4'd6, 4'd2};
      4'd9:  row = {4'd10, 4'd8, 4'd5, 4'd2};
      4'd10: row = {4'd10, 4'd8, 4'd4, 4'd2};
      4'd11: row = {4'd10, 4'd7, 4'd5, 4'd2};
      4'd12: row = {4'd10, 4'd7, 4'd4, 4'd3};
      4'd13: row = {4'd10, 4'd3, 4'd2, 4'd1};
      4'd14: row = {4'd9, 4'd8, 4'd6, 4'd4};
      default: row = {4'd9, 4'd7, 4'd5, 4'd3};
    endcase
    // positive entries are the negative ones less one
    return i[2] ? (row[i[1:0]*4 +: 4] - 4'd1) : row[i[1:0]*4 +: 4];
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    if (v < 0) return 8'd0;
    if (v > 12'sd255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] ext4(input logic [3:0] a);
    return {a, a};
  endfunction

  function automatic logic [7:0] ext5(input logic [4:0] a);
    return {a, a[4:2]};
  endfunction

  function automatic logic [7:0] ext6(input logic [5:0] a);
    return {a, a[5:4]};
  endfunction

  function automatic logic [7:0] ext7(input logic [6:0] a);
    return {a, a[6]};
  endfunction

  function automatic logic signed [3:0] s3(input logic [2:0] a);
    return {a[2], a};
  endfunction

endpackage
`default_nettype wire

[rtl/core/etc2_setup.sv]
// Block setup: mode detection and base colour / alpha parameter extraction.
`default_nettype none
module etc2_setup (
  input  wire logic [63:0]     color_block,
  input  wire logic [63:0]     alpha_block,
  input  wire logic            alpha_on,
  output etc2_pkg::setup_t     setup
);
  import etc2_pkg::*;

  logic [7:0] b0, b1, b2, b3, b4, b5, b6, b7;
  logic signed [5:0] rs, gs, bs;
  logic [7:0] tr1, tg1, tb1, tr2, tg2, tb2;
  logic [7:0] hr1, hg1, hb1, hr2, hg2, hb2;
  logic       hge;

  always_comb begin
    {b0, b1, b2, b3, b4, b5, b6, b7} = color_block;
    rs = $signed({1'b0, b0[7:3]}) + 6'(s3(b0[2:0]));
    gs = $signed({1'b0, b1[7:3]}) + 6'(s3(b1[2:0]));
    bs = $signed({1'b0, b2[7:3]}) + 6'(s3(b2[2:0]));

    tr1 = ext4({b0[4:3], b0[1:0]});
    tg1 = ext4(b1[7:4]);
    tb1 = ext4(b1[3:0]);
    tr2 = ext4(b2[7:4]);
    tg2 = ext4(b2[3:0]);
    tb2 = ext4(b3[7:4]);

    hr1 = ext4(b0[6:3]);
    hg1 = ext4({b0[2:0], b1[4]});
    hb1 = ext4({b1[3], b1[1:0], b2[7]});
    hr2 = ext4(b2[6:3]);
    hg2 = ext4({b2[2:0], b3[7]});
    hb2 = ext4(b3[6:3]);
    hge = {hr1, hg1, hb1} >= {hr2, hg2, hb2};

    setup = '0;
    setup.cw1  = b3[7:5];
    setup.cw2  = b3[4:2];
    setup.flip = b3[0];
    setup.idx  = color_block[31:0];
    setup.alpha_on = alpha_on;
    setup.abase = alpha_block[63:56];
    setup.amult = alpha_block[55:52];
    setup.atab  = alpha_block[51:48];
    setup.aidx  = alpha_block[47:0];
    setup.ro = ext6(b0[6:1]);
    setup.go = ext7({b0[0], b1[6:1]});
    setup.bo = ext6({b1[0], b2[4:3], b2[1:0], b3[7]});
    setup.rh = ext6({b3[6:2], b3[0]});
    setup.gh = ext7(b4[7:1]);
    setup.bh = ext6({b4[0], b5[7:3]});
    setup.rv = ext6({b5[2:0], b6[7:5]});
    setup.gv = ext7({b6[4:0], b7[7:6]});
    setup.bv = ext6(b7[5:0]);

    if (!b3[1]) begin
      setup.mode = MODE_ETC1;
      setup.r1 = ext4(b0[7:4]); setup.r2 = ext4(b0[3:0]);
      setup.g1 = ext4(b1[7:4]); setup.g2 = ext4(b1[3:0]);
      setup.b1 = ext4(b2[7:4]); setup.b2 = ext4(b2[3:0]);
    end else if (rs < 0 || rs > 6'sd31) begin
      setup.mode = MODE_T;
      setup.tdist = dist_lut({b3[3:2], b3[0]});
      {setup.r1, setup.g1, setup.b1, setup.r2, setup.g2, setup.b2} =
        {tr1, tg1, tb1, tr2, tg2, tb2};
    end else if (gs < 0 || gs > 6'sd31) begin
      setup.mode = MODE_H;
      setup.tdist = dist_lut({b3[2], b3[0], hge});
      {setup.r1, setup.g1, setup.b1, setup.r2, setup.g2, setup.b2} =
        {hr1, hg1, hb1, hr2, hg2, hb2};
    end else if (bs < 0 || bs > 6'sd31) begin
      setup.mode = MODE_PLANAR;
    end else begin
      setup.mode = MODE_ETC1;
      setup.r1 = ext5(b0[7:3]); setup.r2 = ext5(rs[4:0]);
      setup.g1 = ext5(b1[7:3]); setup.g2 = ext5(gs[4:0]);
      setup.b1 = ext5(b2[7:3]); setup.b2 = ext5(bs[4:0]);
    end
  end
endmodule
`default_nettype wire

[rtl/core/etc2_lane.sv]
// Pixel lane: decodes one pixel from the block setup.
`default_nettype none
module etc2_lane (
  input  wire etc2_pkg::setup_t setup,
  input  wire logic [1:0]       px_x,
  input  wire logic [1:0]       px_y,
  output logic [31:0]           bgra
);
  import etc2_pkg::*;

  logic [3:0] i;
  logic       msb, lsb, second;
  logic signed [9:0] dl;
  logic [7:0] m;
  logic [7:0] br, bg, bb, r, g, b, a;
  logic [3:0] amag;
  logic [2:0] aidx;
  logic signed [12:0] av;

  function automatic logic [7:0] plan(input logic [7:0] o, input logic [7:0] h,
                                      input logic [7:0] v, input logic [1:0] x,
                                      input logic [1:0] y);
    logic signed [12:0] s;
    s = $signed({3'b0, x}) * ($signed({5'b0, h}) - $signed({5'b0, o}))
      + $signed({3'b0, y}) * ($signed({5'b0, v}) - $signed({5'b0, o}))
      + $signed({3'b0, o, 2'b0}) + 13'sd2;
    return clamp8(12'(s >>> 2));
  endfunction

  always_comb begin
    i   = {px_x, px_y};
    msb = setup.idx[16 + i];
    lsb = setup.idx[i];
    second = setup.flip ? px_y[1] : px_x[1];
    m  = etc1_lut(second ? setup.cw2 : setup.cw1, lsb);
    dl = 10'(0);
    br = second ? setup.r2 : setup.r1;
    bg = second ? setup.g2 : setup.g1;
    bb = second ? setup.b2 : setup.b1;
    r = '0; g = '0; b = '0;
    unique case (setup.mode)
      MODE_ETC1: begin
        dl = msb ? -$signed({2'b0, m}) : $signed({2'b0, m});
      end
      MODE_T: begin
        br = setup.r2; bg = setup.g2; bb = setup.b2;
        unique case ({msb, lsb})
          2'd0: begin br = setup.r1; bg = setup.g1; bb = setup.b1; end
          2'd1: dl = $signed({3'b0, setup.tdist});
          2'd2: dl = 10'(0);
          default: dl = -$signed({3'b0, setup.tdist});
        endcase
      end
      MODE_H: begin
        br = msb ? setup.r2 : setup.r1;
        bg = msb ? setup.g2 : setup.g1;
        bb = msb ? setup.b2 : setup.b1;
        dl = lsb ? -$signed({3'b0, setup.tdist}) : $signed({3'b0, setup.tdist});
      end
      default: dl = 10'(0);
    endcase
    if (setup.mode == MODE_PLANAR) begin
      r = plan(setup.ro, setup.rh, setup.rv, px_x, px_y);
      g = plan(setup.go, setup.gh, setup.gv, px_x, px_y);
      b = plan(setup.bo, setup.bh, setup.bv, px_x, px_y);
    end else begin
      r = clamp8($signed({4'b0, br}) + 12'(dl));
      g = clamp8($signed({4'b0, bg}) + 12'(dl));
      b = clamp8($signed({4'b0, bb}) + 12'(dl));
    end

    aidx = setup.aidx[45 - 3 * i +: 3];
    amag = eac_lut(setup.atab, aidx);
    av = aidx[2]
      ? $signed({5'b0, 8'(amag) * 8'(setup.amult)}) + $signed({5'b0, setup.abase})
      : $signed({5'b0, setup.abase}) - $signed({5'b0, 8'(amag) * 8'(setup.amult)});
    if (setup.alpha_on) begin
      a = clamp8(12'(av));
      if (r > a) r = a;
      if (g > a) g = a;
      if (b > a) b = a;
    end else begin
      a = 8'd255;
    end
    bgra = {a, r, g, b};
  end
endmodule
`default_nettype wire

[rtl/core/etc2_block_decoder.sv]
// Top level: ETC2 RGB8 / EAC RGBA8 4x4 block decoder.
//   channel  direction  handshake        payload
//   in       input      in_valid/stall   color_block, alpha_block
//   out      output     out_valid/stall  pixel_index, pixel_bgra, last_pixel
//   cfg      input      cfg_valid/ready  cfg_data (alpha_enable)
// Sixteen combinational lanes decode a block into a registered pixel bank;
// pixels leave one a cycle while out_stall is low.
// A second bank takes the next block while the first drains.
// Reset clears the bank valids and alpha_enable. Output stall holds the pixel.
`default_nettype none
module etc2_block_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] color_block,
  input  wire logic [63:0] alpha_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       pixel_index,
  output logic [31:0]      pixel_bgra,
  output logic             last_pixel,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  import etc2_pkg::*;

  logic        alpha_enable;
  setup_t      setup;
  logic [31:0] lane_px [16];
  logic [31:0] bank [2][16];
  logic [1:0]  full;
  logic [1:0]  full_next;
  logic        rd, wr;
  logic [3:0]  cnt;

  etc2_setup u_setup (
    .color_block (color_block),
    .alpha_block (alpha_block),
    .alpha_on    (alpha_enable),
    .setup       (setup)
  );

  for (genvar p = 0; p < 16; p++) begin : g_lane
    etc2_lane u_lane (
      .setup (setup),
      .px_x  (2'(p % 4)),
      .px_y  (2'(p / 4)),
      .bgra  (lane_px[p])
    );
  end

  assign cfg_ready   = 1'b1;
  assign in_stall    = full[wr];
  assign out_valid   = full[rd];
  assign pixel_index = cnt;
  assign pixel_bgra  = bank[rd][cnt];
  assign last_pixel  = (cnt == 4'd15);

  always_comb begin
    full_next = full;
    if (in_valid && !full[wr]) full_next[wr] = 1'b1;
    if (full[rd] && !out_stall && cnt == 4'd15) full_next[rd] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_enable <= 1'b0;
      full <= '0;
      rd <= 1'b0;
      wr <= 1'b0;
      cnt <= '0;
    end else begin
      if (cfg_valid) alpha_enable <= cfg_data;
      full <= full_next;
      if (in_valid && !full[wr]) wr <= ~wr;
      if (full[rd] && !out_stall) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) rd <= ~rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !full[wr]) bank[wr] <= lane_px;
  end
endmodule
`default_nettype wire
